// ===== rtl/rsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rsp_pkg: shared types and constants
// Operand codes, step table, command/status structs and saturation helper
// for the rotated support point core.
// ----------------------------------------------------------------------------
package rsp_pkg;

  localparam int NUM_STEPS = 18;
  localparam int STEP_W    = 5;

  typedef enum logic [3:0] {
    A_VX, A_VY, A_VZ, A_T0, A_T1, A_T2, A_RX, A_RY, A_RZ
  } a_sel_t;

  typedef enum logic [2:0] {
    B_W, B_QX, B_QY, B_QZ, B_DX, B_DY, B_DZ
  } b_sel_t;

  typedef enum logic [2:0] {
    D_NONE, D_T0, D_T1, D_T2, D_R0, D_R1, D_R2, D_DOT
  } dest_t;

  typedef enum logic [2:0] {
    REG_ROT_W = 3'd0,
    REG_ROT_X = 3'd1,
    REG_ROT_Y = 3'd2,
    REG_ROT_Z = 3'd3,
    REG_POS_X = 3'd4,
    REG_POS_Y = 3'd5,
    REG_POS_Z = 3'd6,
    REG_NONE  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_RUN, ST_DRAIN, ST_UPDATE
  } state_t;

  typedef struct packed {
    a_sel_t a_sel;
    b_sel_t b_sel;
    logic   neg;
    logic   first;
    dest_t  dest;
  } step_op_t;

  typedef struct packed {
    logic              load;
    logic              issue;
    logic [STEP_W-1:0] step;
    logic              update;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic out_full;
  } dp_status_t;

  localparam step_op_t STEP_TABLE [NUM_STEPS] = '{
    '{A_VZ, B_QY, 1'b0, 1'b1, D_NONE},
    '{A_VY, B_QZ, 1'b1, 1'b0, D_T0},
    '{A_VX, B_QZ, 1'b0, 1'b1, D_NONE},
    '{A_VZ, B_QX, 1'b1, 1'b0, D_T1},
    '{A_VY, B_QX, 1'b0, 1'b1, D_NONE},
    '{A_VX, B_QY, 1'b1, 1'b0, D_T2},
    '{A_T0, B_W,  1'b0, 1'b1, D_NONE},
    '{A_T2, B_QY, 1'b0, 1'b0, D_NONE},
    '{A_T1, B_QZ, 1'b1, 1'b0, D_R0},
    '{A_T1, B_W,  1'b0, 1'b1, D_NONE},
    '{A_T0, B_QZ, 1'b0, 1'b0, D_NONE},
    '{A_T2, B_QX, 1'b1, 1'b0, D_R1},
    '{A_T2, B_W,  1'b0, 1'b1, D_NONE},
    '{A_T1, B_QX, 1'b0, 1'b0, D_NONE},
    '{A_T0, B_QY, 1'b1, 1'b0, D_R2},
    '{A_RX, B_DX, 1'b0, 1'b1, D_NONE},
    '{A_RY, B_DY, 1'b0, 1'b0, D_NONE},
    '{A_RZ, B_DZ, 1'b0, 1'b0, D_DOT}
  };

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/rsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsp_ctrl: sequencer
// Accepts an item, steps the shared multiplier through the product table,
// then commits the compare and any result.
// ----------------------------------------------------------------------------
module rsp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rsp_pkg::dp_status_t status,
  output rsp_pkg::dp_cmd_t    cmd
);

  rsp_pkg::state_t state, state_next;
  logic [rsp_pkg::STEP_W-1:0] step, step_next;
  logic last_step;

  assign last_step = (step == rsp_pkg::STEP_W'(rsp_pkg::NUM_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsp_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      rsp_pkg::ST_IDLE: begin
        step_next = '0;
        if (in_valid) state_next = rsp_pkg::ST_RUN;
      end
      rsp_pkg::ST_RUN: begin
        if (last_step) begin
          step_next  = '0;
          state_next = rsp_pkg::ST_DRAIN;
        end else begin
          step_next = step + 1'b1;
        end
      end
      rsp_pkg::ST_DRAIN: begin
        state_next = rsp_pkg::ST_UPDATE;
      end
      rsp_pkg::ST_UPDATE: begin
        if (!(status.last && status.out_full)) state_next = rsp_pkg::ST_IDLE;
      end
      default: state_next = rsp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == rsp_pkg::ST_IDLE);
    cmd.load   = in_ready && in_valid;
    cmd.issue  = (state == rsp_pkg::ST_RUN);
    cmd.step   = step;
    cmd.update = (state == rsp_pkg::ST_UPDATE) && !(status.last && status.out_full);
  end

endmodule

// ===== rtl/rsp_datapath.sv =====
// ----------------------------------------------------------------------------
// rsp_datapath: rotation, dot product and support selection
// One shared 32x24 multiplier with a registered product and a 64-bit
// accumulator; holds configuration, kept vertex and output register.
// ----------------------------------------------------------------------------
module rsp_datapath (
  input  logic                clk,
  input  logic                rst,
  input  rsp_pkg::dp_cmd_t    cmd,
  output rsp_pkg::dp_status_t status,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic signed [31:0]  vert_x,
  input  logic signed [31:0]  vert_y,
  input  logic signed [31:0]  vert_z,
  input  logic signed [23:0]  dir_x,
  input  logic signed [23:0]  dir_y,
  input  logic signed [23:0]  dir_z,
  input  logic                last_vertex,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  support_x,
  output logic signed [31:0]  support_y,
  output logic signed [31:0]  support_z
);

  logic signed [15:0] rot_w, rot_x, rot_y, rot_z;
  logic signed [31:0] pos_x, pos_y, pos_z;

  logic signed [31:0] vx, vy, vz, t0, t1, t2, rx, ry, rz;
  logic signed [23:0] dx, dy, dz;
  logic               last;

  logic               query_open;
  logic signed [63:0] best_dot;
  logic signed [31:0] best_px, best_py, best_pz;

  rsp_pkg::step_op_t  op, op_d;
  logic               p_valid;
  logic signed [31:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [55:0] prod;
  logic signed [63:0] acc, acc_next, addend;

  logic               keep;
  logic signed [31:0] sel_x, sel_y, sel_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_w <= 16'sd16384;
      rot_x <= '0;
      rot_y <= '0;
      rot_z <= '0;
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (cfg_we) begin
      unique case (rsp_pkg::reg_idx_t'(cfg_index))
        rsp_pkg::REG_ROT_W: rot_w <= cfg_data[15:0];
        rsp_pkg::REG_ROT_X: rot_x <= cfg_data[15:0];
        rsp_pkg::REG_ROT_Y: rot_y <= cfg_data[15:0];
        rsp_pkg::REG_ROT_Z: rot_z <= cfg_data[15:0];
        rsp_pkg::REG_POS_X: pos_x <= cfg_data;
        rsp_pkg::REG_POS_Y: pos_y <= cfg_data;
        rsp_pkg::REG_POS_Z: pos_z <= cfg_data;
        rsp_pkg::REG_NONE:  ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx   <= vert_x;
      vy   <= vert_y;
      vz   <= vert_z;
      dx   <= dir_x;
      dy   <= dir_y;
      dz   <= dir_z;
      last <= last_vertex;
    end
  end

  assign op = rsp_pkg::STEP_TABLE[cmd.step];

  always_comb begin
    unique case (op.a_sel)
      rsp_pkg::A_VX: mul_a = vx;
      rsp_pkg::A_VY: mul_a = vy;
      rsp_pkg::A_VZ: mul_a = vz;
      rsp_pkg::A_T0: mul_a = t0;
      rsp_pkg::A_T1: mul_a = t1;
      rsp_pkg::A_T2: mul_a = t2;
      rsp_pkg::A_RX: mul_a = rx;
      rsp_pkg::A_RY: mul_a = ry;
      rsp_pkg::A_RZ: mul_a = rz;
      default:       mul_a = '0;
    endcase
    unique case (op.b_sel)
      rsp_pkg::B_W:  mul_b = 24'(rot_w);
      rsp_pkg::B_QX: mul_b = 24'(rot_x);
      rsp_pkg::B_QY: mul_b = 24'(rot_y);
      rsp_pkg::B_QZ: mul_b = 24'(rot_z);
      rsp_pkg::B_DX: mul_b = dx;
      rsp_pkg::B_DY: mul_b = dy;
      rsp_pkg::B_DZ: mul_b = dz;
      default:       mul_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    op_d <= op;
  end

  always_comb begin
    addend   = op_d.neg ? -64'(prod) : 64'(prod);
    acc_next = (op_d.first ? 64'sd0 : acc) + addend;
  end

  always_ff @(posedge clk) begin
    if (p_valid) begin
      acc <= acc_next;
      unique case (op_d.dest)
        rsp_pkg::D_T0: t0 <= rsp_pkg::sat32(acc_next >>> 13);
        rsp_pkg::D_T1: t1 <= rsp_pkg::sat32(acc_next >>> 13);
        rsp_pkg::D_T2: t2 <= rsp_pkg::sat32(acc_next >>> 13);
        rsp_pkg::D_R0: rx <= rsp_pkg::sat32(64'(vx) + (acc_next >>> 14));
        rsp_pkg::D_R1: ry <= rsp_pkg::sat32(64'(vy) + (acc_next >>> 14));
        rsp_pkg::D_R2: rz <= rsp_pkg::sat32(64'(vz) + (acc_next >>> 14));
        default: ;
      endcase
    end
  end

  always_comb begin
    keep  = !query_open || (acc > best_dot);
    sel_x = keep ? rx : best_px;
    sel_y = keep ? ry : best_py;
    sel_z = keep ? rz : best_pz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_open <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.update) begin
        query_open <= !last;
        if (last) out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (keep) begin
        best_dot <= acc;
        best_px  <= rx;
        best_py  <= ry;
        best_pz  <= rz;
      end
      if (last) begin
        support_x <= rsp_pkg::sat32(64'(sel_x) + 64'(pos_x));
        support_y <= rsp_pkg::sat32(64'(sel_y) + 64'(pos_y));
        support_z <= rsp_pkg::sat32(64'(sel_z) + 64'(pos_z));
      end
    end
  end

  assign status.last     = last;
  assign status.out_full = out_valid && !out_ready;

endmodule

// ===== rtl/rotated_support_point.sv =====
// ----------------------------------------------------------------------------
// rotated_support_point_core: support mapping of a rotated convex polytope
// Flow: an accepted vertex steps 18 products through one shared multiplier,
// drains the product register and commits, raising out_valid on a last vertex;
// a new vertex is accepted only after that commit; a waiting result stalls a last commit.
// Reset: identity rotation, zero position, query closed, no result pending.
// ----------------------------------------------------------------------------
module rotated_support_point_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] vert_x,
  input  logic signed [31:0] vert_y,
  input  logic signed [31:0] vert_z,
  input  logic signed [23:0] dir_x,
  input  logic signed [23:0] dir_y,
  input  logic signed [23:0] dir_z,
  input  logic               last_vertex,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] support_x,
  output logic signed [31:0] support_y,
  output logic signed [31:0] support_z
);

  rsp_pkg::dp_cmd_t    cmd;
  rsp_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  rsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rsp_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .vert_x      (vert_x),
    .vert_y      (vert_y),
    .vert_z      (vert_z),
    .dir_x       (dir_x),
    .dir_y       (dir_y),
    .dir_z       (dir_z),
    .last_vertex (last_vertex),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .support_x   (support_x),
    .support_y   (support_y),
    .support_z   (support_z)
  );

endmodule
